### rtl/core/nfsc_pkg.sv
// Shared constants and types for the nibble framer with stuffing and checksum.
// No dependencies; the interfaces and the top level import this package.
`timescale 1ns / 1ps

package nfsc_pkg;

  localparam int unsigned NibW       = 4;
  localparam int unsigned KindW      = 2;
  localparam int unsigned SumW       = 8;
  localparam int unsigned MaxResults = 7;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);
  localparam int unsigned IdxW       = $clog2(MaxResults);

  localparam logic [NibW-1:0] FLAG_FIRST  = 4'b0111;
  localparam logic [NibW-1:0] FLAG_SECOND = 4'b1110;
  localparam logic [NibW-1:0] STUFF_NIB   = 4'b0000;
  localparam logic [SumW-1:0] CHECK_MOD   = 8'b10001001;

  typedef enum logic [KindW-1:0] {
    KIND_FLAG    = 2'd0,
    KIND_STUFF   = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_CHECK   = 2'd3
  } nib_kind_e;

  typedef struct packed {
    logic [NibW-1:0] nibble;
    nib_kind_e       kind;
  } line_beat_t;

endpackage

### rtl/core/nfsc_if.sv
// Valid/ready channel interfaces for payload nibbles in and line nibbles out.
// Depends on nfsc_pkg for field widths.
`timescale 1ns / 1ps

interface nfsc_in_if
  import nfsc_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [NibW-1:0] nibble;
  logic            frame_last;

  modport source (output valid, output nibble, output frame_last, input ready);
  modport sink   (input valid, input nibble, input frame_last, output ready);
endinterface

interface nfsc_out_if
  import nfsc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [NibW-1:0]  out_nibble;
  logic [KindW-1:0] nibble_kind;
  logic             run_end;

  modport source (output valid, output out_nibble, output nibble_kind, output run_end,
                  input ready);
  modport sink   (input valid, input out_nibble, input nibble_kind, input run_end,
                  output ready);
endinterface

### rtl/core/nibble_framer_stuff_checksum_top.sv
// Nibble framer: flag delimiting, zero-nibble stuffing and a modulo-137 checksum.
// Depends on nfsc_pkg and the nfsc_in_if / nfsc_out_if interfaces.
`timescale 1ns / 1ps

// One payload nibble in gives one to seven line nibbles out, one beat per cycle
// while the output is ready: two opening flags at frame start, a stuffed zero where
// 0111 is followed by 1110, the payload nibble, and on the last nibble two checksum
// nibbles and two closing flags. The output port sets the rate. An item is taken
// into the input register while the previous item's beats are still being sent;
// its beats are built in one pass and load the output buffer as the last beat
// before them leaves.
module nibble_framer_stuff_checksum_top
  import nfsc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  nfsc_in_if.sink   in_i,
  nfsc_out_if.source out_o
);

  logic            a_valid_q;
  logic [NibW-1:0] a_nib_q;
  logic            a_last_q;

  logic            in_frame_q;
  logic            prev_valid_q;
  logic [NibW-1:0] prev_q;
  logic [SumW-1:0] sum_q;

  logic            b_valid_q;
  logic [CntW-1:0] b_cnt_q;
  logic [IdxW-1:0] b_idx_q;
  line_beat_t      seq_q [MaxResults];

  line_beat_t      seq_d [MaxResults];
  logic [CntW-1:0] cnt_d;
  logic [SumW-1:0] sum_d;

  logic            b_last_beat;
  logic            out_take;
  logic            a_move;
  logic            in_take;

  assign b_last_beat = (CntW'(b_idx_q) == b_cnt_q - CntW'(1));
  assign out_take    = b_valid_q && out_o.ready;
  assign a_move      = a_valid_q && (!b_valid_q || (out_take && b_last_beat));
  assign in_i.ready  = !a_valid_q || a_move;
  assign in_take     = in_i.valid && in_i.ready;

  always_comb begin
    logic [SumW-1:0] sum_base;
    logic [SumW-1:0] sum_raw;
    logic [CntW-1:0] n;
    sum_base = in_frame_q ? sum_q : '0;
    sum_raw  = sum_base + SumW'(a_nib_q);
    sum_d    = (sum_raw >= CHECK_MOD) ? sum_raw - CHECK_MOD : sum_raw;
    n        = '0;
    for (int i = 0; i < MaxResults; i++) begin
      seq_d[i] = '{nibble: STUFF_NIB, kind: KIND_FLAG};
    end
    if (!in_frame_q) begin
      seq_d[n[IdxW-1:0]] = '{nibble: FLAG_FIRST, kind: KIND_FLAG};
      n = n + CntW'(1);
      seq_d[n[IdxW-1:0]] = '{nibble: FLAG_SECOND, kind: KIND_FLAG};
      n = n + CntW'(1);
    end
    if (in_frame_q && prev_valid_q && prev_q == FLAG_FIRST && a_nib_q == FLAG_SECOND) begin
      seq_d[n[IdxW-1:0]] = '{nibble: STUFF_NIB, kind: KIND_STUFF};
      n = n + CntW'(1);
    end
    seq_d[n[IdxW-1:0]] = '{nibble: a_nib_q, kind: KIND_PAYLOAD};
    n = n + CntW'(1);
    if (a_last_q) begin
      seq_d[n[IdxW-1:0]] = '{nibble: sum_d[SumW-1:NibW], kind: KIND_CHECK};
      n = n + CntW'(1);
      seq_d[n[IdxW-1:0]] = '{nibble: sum_d[NibW-1:0], kind: KIND_CHECK};
      n = n + CntW'(1);
      seq_d[n[IdxW-1:0]] = '{nibble: FLAG_FIRST, kind: KIND_FLAG};
      n = n + CntW'(1);
      seq_d[n[IdxW-1:0]] = '{nibble: FLAG_SECOND, kind: KIND_FLAG};
      n = n + CntW'(1);
    end
    cnt_d = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q    <= 1'b0;
      in_frame_q   <= 1'b0;
      prev_valid_q <= 1'b0;
      prev_q       <= '0;
      sum_q        <= '0;
      b_valid_q    <= 1'b0;
      b_cnt_q      <= '0;
      b_idx_q      <= '0;
    end else begin
      if (in_take) begin
        a_valid_q <= 1'b1;
      end else if (a_move) begin
        a_valid_q <= 1'b0;
      end
      if (a_move) begin
        in_frame_q   <= !a_last_q;
        prev_valid_q <= !a_last_q;
        prev_q       <= a_nib_q;
        sum_q        <= sum_d;
        b_valid_q    <= 1'b1;
        b_cnt_q      <= cnt_d;
        b_idx_q      <= '0;
      end else if (out_take) begin
        if (b_last_beat) begin
          b_valid_q <= 1'b0;
        end else begin
          b_idx_q <= b_idx_q + IdxW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      a_nib_q  <= in_i.nibble;
      a_last_q <= in_i.frame_last;
    end
    if (a_move) begin
      seq_q <= seq_d;
    end
  end

  assign out_o.valid       = b_valid_q;
  assign out_o.out_nibble  = seq_q[b_idx_q].nibble;
  assign out_o.nibble_kind = KindW'(seq_q[b_idx_q].kind);
  assign out_o.run_end     = b_last_beat;

endmodule
